>>> design/uist_pkg.sv
// Shared widths, codes and control structs of the unique item set table.
package uist_pkg;

   localparam int ITEM_W       = 32;
   localparam int ITEM_COUNT_W = 7;
   localparam int STATUS_W     = 2;
   localparam int DEF_CAPACITY = 64;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 16;
   localparam int RSP_PAD_W   = RSP_TDATA_W - STATUS_W - ITEM_COUNT_W;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic                load;
      logic                scan;
      logic                shift_start;
      logic                shift;
      logic                append;
      logic                remove;
      logic                rsp_load;
      logic [STATUS_W-1:0] rsp_code;
   } cmd_type;

   typedef struct packed {
      logic func;
      logic hit;
      logic drained;
      logic full;
      logic rsp_busy;
   } sts_type;

endpackage

>>> design/uist_ctrl.sv
// Controller state machine: sequences scan, tail shift and reply of each request.
module uist_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  uist_pkg::sts_type sts,
   output uist_pkg::cmd_type cmd
);
   import uist_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;
   localparam logic [1:0] S_REPLY = 2'd3;

   logic [1:0]          state_ff;
   logic [1:0]          state_in;
   logic [STATUS_W-1:0] code_ff;
   logic [STATUS_W-1:0] code_in;

   always_comb begin
      state_in   = state_ff;
      code_in    = code_ff;
      cmd        = '0;
      cmd.rsp_code = code_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.hit) begin
               if (sts.func == OP_REMOVE) begin
                  cmd.shift_start = 1'b1;
                  state_in        = S_SHIFT;
               end else begin
                  code_in  = ST_MISS;
                  state_in = S_REPLY;
               end
            end else if (sts.drained) begin
               priority if (sts.func == OP_REMOVE) begin
                  code_in = ST_MISS;
               end else if (sts.full) begin
                  code_in = ST_FULL;
               end else begin
                  cmd.append = 1'b1;
                  code_in    = ST_DONE;
               end
               state_in = S_REPLY;
            end
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (sts.drained) begin
               cmd.remove = 1'b1;
               code_in    = ST_DONE;
               state_in   = S_REPLY;
            end
         end
         S_REPLY: begin
            if (!sts.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= ST_DONE;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

endmodule

>>> design/uist_dpath.sv
// Datapath: entry memory, fill count, scan and shift indexes, response register.
module uist_dpath #(
   parameter int CAPACITY = uist_pkg::DEF_CAPACITY
) (
   input  logic                               clock,
   input  logic                               reset,
   input  uist_pkg::cmd_type                  cmd,
   output uist_pkg::sts_type                  sts,
   input  logic [uist_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [uist_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import uist_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic [ITEM_W-1:0] mem [CAPACITY];

   logic                    func_ff;
   logic [ITEM_W-1:0]       value_ff;
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic [CNT_W-1:0]        idx_ff;
   logic [CNT_W-1:0]        idx_in;
   logic                    rd_vld_ff;
   logic                    rd_vld_in;
   logic [CNT_W-1:0]        rd_idx_ff;
   logic [ITEM_W-1:0]       rd_data_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff;
   logic [ITEM_COUNT_W-1:0] rsp_count_ff;

   logic              rd_en;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [ITEM_W-1:0] wr_data;
   logic [CNT_W-1:0]  back_idx;
   logic              more;

   assign more     = idx_ff < count_ff;
   assign back_idx = CNT_W'(rd_idx_ff - 1'b1);

   assign sts.func     = func_ff;
   assign sts.hit      = rd_vld_ff && (rd_data_ff == value_ff);
   assign sts.drained  = !rd_vld_ff && !more;
   assign sts.full     = count_ff >= CNT_W'(CAPACITY);
   assign sts.rsp_busy = rsp_valid_ff && !rsp_tready;

   always_comb begin
      idx_in    = idx_ff;
      rd_vld_in = rd_vld_ff;
      rd_en     = 1'b0;
      priority if (cmd.load) begin
         idx_in    = '0;
         rd_vld_in = 1'b0;
      end else if (cmd.shift_start) begin
         idx_in    = CNT_W'(rd_idx_ff + 1'b1);
         rd_vld_in = 1'b0;
      end else if (cmd.scan || cmd.shift) begin
         rd_en     = more;
         rd_vld_in = more;
         if (more) begin
            idx_in = CNT_W'(idx_ff + 1'b1);
         end
      end else begin
         rd_vld_in = 1'b0;
      end
   end

   always_comb begin
      wr_en   = cmd.append || (cmd.shift && rd_vld_ff);
      wr_addr = cmd.append ? count_ff[AW-1:0] : back_idx[AW-1:0];
      wr_data = cmd.append ? value_ff : rd_data_ff;
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.append) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (cmd.remove) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_comb begin
      priority if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[idx_ff[AW-1:0]];
         rd_idx_ff  <= idx_ff;
      end
      if (cmd.load) begin
         func_ff  <= req_tdata[0];
         value_ff <= req_tdata[ITEM_W:1];
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_code;
         rsp_count_ff  <= ITEM_COUNT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_count_ff, rsp_status_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("fill count above capacity");

   a_no_append_full: assert property (@(posedge clock) disable iff (reset)
      cmd.append |-> count_ff < CNT_W'(CAPACITY))
      else $error("append into a full table");

   a_no_remove_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.remove |-> count_ff != '0)
      else $error("remove from an empty table");

   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid_ff && !rsp_tready))
      else $error("response overwritten while stalled");

   a_shift_write_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.shift && rd_vld_ff) |-> (rd_idx_ff != '0 && rd_idx_ff < count_ff))
      else $error("shift write outside held entries");

endmodule

>>> design/unique_item_set_table_unit.sv
// Top level of the unique item set table: controller plus datapath.
//
//   channel | direction | tdata fields (lowest bit up)         | tuser
//   req_    | in        | func[0], item_value[32:1], zero pad  | -
//   rsp_    | out       | status[1:0], item_count[8:2], pad    | -
//
// One request at a time. A request is accepted in the idle state, then scans the held
// entries, then passes through the reply state and back to idle before the next accept.
// Remove: scan up to the match, then shift the entries behind it down by one place
// through one read and one write port.
// Reset clears the count; the entry memory needs no clearing pass.
// A result waiting on a stalled rsp_ side holds the next request in its reply.
module unique_item_set_table_unit #(
   parameter int CAPACITY = uist_pkg::DEF_CAPACITY
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // func[0], item_value[32:1], zeros[39:33]
   input  logic [uist_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status[1:0], item_count[8:2], zeros[15:9]
   output logic [uist_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import uist_pkg::*;

   cmd_type cmd;
   sts_type sts;

   uist_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   uist_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> dv/tb.sv
// Testbench for the unique item set table: shadow table, stream drivers and reply checks.
module tb;
   import uist_pkg::*;

   localparam int CAPACITY   = DEF_CAPACITY;
   localparam int POOL_SIZE  = 80;
   localparam int ITEM_GOAL  = 1800;
   localparam int SETTLE     = 2 * CAPACITY + 12;
   localparam int LIMIT      = 1500000;

   localparam int MODE_FILL  = 0;
   localparam int MODE_DRAIN = 1;
   localparam int MODE_MIXED = 2;

   localparam int IDLE_NONE  = 0;
   localparam int IDLE_FULL  = 1;
   localparam int IDLE_SOME  = 2;

   class shadow_set_table;
      typedef struct {
         logic [STATUS_W-1:0]     status;
         logic [ITEM_COUNT_W-1:0] count;
      } reply_type;

      logic [ITEM_W-1:0] entries [CAPACITY];
      int                held;
      reply_type         due_replies [$];
      int                mismatch_count;
      int                request_count;
      int                reply_count;
      int                tally [3];

      function new();
         held = 0;
         mismatch_count = 0;
         request_count = 0;
         reply_count = 0;
         tally = '{0, 0, 0};
      endfunction

      task report(string msg);
         $display("ERROR at %0t: %s", $time, msg);
         mismatch_count++;
      endtask

      function void note_request(logic func, logic [ITEM_W-1:0] value);
         int        pos;
         int        i;
         reply_type r;
         pos = held;
         for (i = 0; i < held && pos == held; i++)
            if (entries[i] == value)
               pos = i;
         if (func == OP_INSERT) begin
            if (pos < held) begin
               r.status = ST_MISS;
            end else if (held >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               entries[held] = value;
               held++;
               r.status = ST_DONE;
            end
         end else begin
            if (pos < held) begin
               for (i = pos; i + 1 < held; i++)
                  entries[i] = entries[i + 1];
               held--;
               r.status = ST_DONE;
            end else begin
               r.status = ST_MISS;
            end
         end
         r.count = ITEM_COUNT_W'(held);
         due_replies.push_back(r);
         tally[r.status]++;
         request_count++;
      endfunction

      task check_reply(logic [STATUS_W-1:0] status, logic [ITEM_COUNT_W-1:0] count);
         reply_type r;
         reply_count++;
         if (due_replies.size() == 0) begin
            report($sformatf("reply with none due: status %0d count %0d", status, count));
         end else begin
            r = due_replies.pop_front();
            if (status !== r.status)
               report($sformatf("reply %0d status %0d, want %0d", reply_count, status,
                                r.status));
            if (count !== r.count)
               report($sformatf("reply %0d count %0d, want %0d", reply_count, count,
                                r.count));
         end
      endtask
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   shadow_set_table sb = new();
   int              req_idle_mode = IDLE_FULL;
   int              rsp_idle_mode = IDLE_FULL;
   int              cycle_count = 0;
   int              full_hits = 0;

   unique_item_set_table_unit #(.CAPACITY(CAPACITY)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic int draw_wait(int mode);
      if (mode == IDLE_NONE)
         return 0;
      if (mode == IDLE_SOME)
         return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
      return $urandom_range(0, 19);
   endfunction

   task automatic send_request(input logic func, input logic [ITEM_W-1:0] value);
      int gap;
      gap = draw_wait(req_idle_mode);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {{(REQ_TDATA_W - 1 - ITEM_W){1'b0}}, value, func};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_request(func, value);
      if (sb.held == CAPACITY && func == OP_INSERT)
         full_hits++;
   endtask

   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.due_replies.size() != 0);
   endtask

   initial begin : reply_side
      int stall;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (sb.reply_count % 64 == 0)
            rsp_idle_mode = $urandom_range(IDLE_NONE, IDLE_SOME);
         stall = draw_wait(rsp_idle_mode);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         sb.check_reply(rsp_tdata[STATUS_W-1:0], rsp_tdata[STATUS_W +: ITEM_COUNT_W]);
      end
   end

   initial begin : watchdog
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
               sb.due_replies.size());
      $display("unique_item_set_table_unit: mismatch");
      $finish;
   end

   initial begin : stimulus
      logic [ITEM_W-1:0] pool [POOL_SIZE];
      logic [ITEM_W-1:0] value;
      logic              func;
      int                seg_len;
      int                mode;
      int                ins_pct;
      int                roll;
      int                k;
      bit                first_seg;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, duplicates, extreme patterns, remove first/middle/last
      send_request(OP_REMOVE, 32'h0000_0000);
      send_request(OP_INSERT, 32'h0000_0000);
      send_request(OP_INSERT, 32'h0000_0000);
      send_request(OP_INSERT, 32'h7FFF_FFFF);
      send_request(OP_INSERT, 32'h8000_0000);
      send_request(OP_INSERT, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 32'h0000_0001);
      send_request(OP_INSERT, 32'hAAAA_AAAA);
      send_request(OP_INSERT, 32'h5555_5555);
      send_request(OP_INSERT, 32'hFFFF_FFFF);
      send_request(OP_REMOVE, 32'h8000_0000);
      send_request(OP_REMOVE, 32'h8000_0000);
      send_request(OP_REMOVE, 32'h0000_0000);
      send_request(OP_REMOVE, 32'h5555_5555);
      send_request(OP_REMOVE, 32'h1234_5678);
      send_request(OP_INSERT, 32'h8000_0000);
      send_request(OP_REMOVE, 32'h7FFF_FFFF);
      send_request(OP_REMOVE, 32'hFFFF_FFFF);
      send_request(OP_REMOVE, 32'h0000_0001);
      send_request(OP_REMOVE, 32'hAAAA_AAAA);
      send_request(OP_REMOVE, 32'h8000_0000);
      send_request(OP_REMOVE, 32'h8000_0000);
      hold_until_drained();

      first_seg = 1'b1;
      while (sb.request_count < ITEM_GOAL) begin
         for (k = 0; k < POOL_SIZE; k++)
            pool[k] = $urandom();
         pool[0] = 32'h8000_0000;
         pool[1] = 32'h7FFF_FFFF;
         pool[2] = 32'hFFFF_FFFF;
         pool[3] = 32'h0000_0000;
         if (first_seg) begin
            mode = MODE_FILL;
            seg_len = 110;
            req_idle_mode = IDLE_NONE;
         end else begin
            mode = $urandom_range(MODE_FILL, MODE_MIXED);
            seg_len = $urandom_range(30, 120);
            req_idle_mode = $urandom_range(IDLE_NONE, IDLE_SOME);
         end
         first_seg = 1'b0;
         ins_pct = (mode == MODE_FILL) ? 90 : (mode == MODE_DRAIN) ? 25 : 55;
         for (k = 0; k < seg_len; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
               func  = 1'($urandom_range(0, 1));
               value = $urandom();
            end else if (roll < ins_pct) begin
               func = OP_INSERT;
               if (sb.held > 0 && $urandom_range(0, 4) == 0)
                  value = sb.entries[$urandom_range(0, sb.held - 1)];
               else
                  value = pool[$urandom_range(0, POOL_SIZE - 1)];
            end else begin
               func = OP_REMOVE;
               if (sb.held > 0 && $urandom_range(0, 3) != 0)
                  value = sb.entries[$urandom_range(0, sb.held - 1)];
               else
                  value = pool[$urandom_range(0, POOL_SIZE - 1)];
            end
            send_request(func, value);
         end
         if ($urandom_range(0, 2) == 0)
            hold_until_drained();
      end
      req_tvalid <= 1'b0;

      while (sb.due_replies.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (sb.due_replies.size() != 0)
         sb.report($sformatf("%0d replies never arrived", sb.due_replies.size()));

      $display("%0d requests sent, %0d replies checked in %0d cycles", sb.request_count,
               sb.reply_count, cycle_count);
      $display("replies: %0d done, %0d duplicate or absent, %0d full; %0d inserts at capacity",
               sb.tally[ST_DONE], sb.tally[ST_MISS], sb.tally[ST_FULL], full_hits);
      if (sb.mismatch_count == 0) begin
         $display("unique_item_set_table_unit: match");
      end else begin
         $display("unique_item_set_table_unit: mismatch");
      end
      $finish;
   end

endmodule
